// ===== rtl/brotli_distance_decoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// brotli_distance_decoder_core_macros.svh
// Assertion macros used by the distance decoder checker.
// ----------------------------------------------------------------------------
`ifndef BROTLI_DISTANCE_DECODER_CORE_MACROS_SVH
`define BROTLI_DISTANCE_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BDD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BDD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bdd_pkg.sv =====
// ----------------------------------------------------------------------------
// bdd_pkg
// Types and constants of the distance decoder.
// ----------------------------------------------------------------------------
package bdd_pkg;

  localparam int unsigned RingDepth  = 4;
  localparam int unsigned RingWidth  = 24;
  localparam int unsigned SymWidth   = 10;
  localparam int unsigned PeekWidth  = 24;
  localparam int unsigned PosWidth   = 32;
  localparam int unsigned DistWidth  = 30;
  localparam int unsigned UsedWidth  = 5;
  localparam int unsigned PfxWidth   = 2;
  localparam int unsigned DirWidth   = 7;
  localparam int unsigned WinWidth   = 5;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 7;
  localparam int unsigned InDataWidth  = 72;
  localparam int unsigned OutDataWidth = 40;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CFG_POSTFIX_BITS = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_DIRECT_CODES = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_WINDOW_BITS  = 2'd2;

  localparam logic [WinWidth-1:0] WINDOW_BITS_RST = 5'd16;
  localparam logic [32:0] WINDOW_SLACK = 33'd16;
  localparam logic [24:0] REL_LIMIT = 25'h100_0000;

  typedef logic [RingDepth-1:0][RingWidth-1:0] ring_t;

  // entry 0 is the newest
  localparam ring_t RING_START = {24'd16, 24'd15, 24'd11, 24'd4};

  localparam logic [1:0] RING_PICK [16] = '{
    2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1
  };

  localparam logic signed [2:0] RING_ADJUST [16] = '{
    3'sd0, 3'sd0, 3'sd0, 3'sd0, -3'sd1, 3'sd1, -3'sd2, 3'sd2,
    -3'sd3, 3'sd3, -3'sd1, 3'sd1, -3'sd2, 3'sd2, -3'sd3, 3'sd3
  };

  typedef struct packed {
    logic                 implicit_last;
    logic [SymWidth-1:0]  distance_symbol;
    logic [PeekWidth-1:0] peek_bits;
    logic [PosWidth-1:0]  output_position;
  } item_t;

  typedef struct packed {
    logic [DistWidth-1:0] resolved_distance;
    logic [UsedWidth-1:0] bits_consumed;
    logic                 dictionary_ref;
    logic                 invalid_distance;
  } result_t;

  typedef struct packed {
    logic                 push;
    logic [RingWidth-1:0] ring_dist;
  } ring_upd_t;

endpackage

// ===== rtl/bdd_resolve.sv =====
// ----------------------------------------------------------------------------
// bdd_resolve
// Combinational distance resolution for one symbol against the ring.
// ----------------------------------------------------------------------------
module bdd_resolve (
  input  bdd_pkg::item_t                  item_i,
  input  bdd_pkg::ring_t                  ring_i,
  input  logic [bdd_pkg::PfxWidth-1:0]    postfix_bits_i,
  input  logic [bdd_pkg::DirWidth-1:0]    direct_codes_i,
  input  logic [bdd_pkg::WinWidth-1:0]    window_bits_i,
  output bdd_pkg::result_t                result_o,
  output bdd_pkg::ring_upd_t              upd_o
);
  import bdd_pkg::*;

  logic [SymWidth-1:0]  sym;
  logic [23:0]          ring_sel;
  logic signed [2:0]    adj;
  logic [25:0]          rel_sum;
  logic                 rel_bad;
  logic [10:0]          direct_end;
  logic                 in_direct;
  logic [9:0]           rel;
  logic [9:0]           alpha_size;
  logic [2:0]           nshift;
  logic [9:0]           rel_hi;
  logic [UsedWidth-1:0] nbits;
  logic                 hcode_lsb;
  logic [2:0]           lmask;
  logic [2:0]           lcode;
  logic [24:0]          emask;
  logic [23:0]          extra;
  logic [26:0]          offset;
  logic [26:0]          base;
  logic [DistWidth-1:0] ext_dist;
  logic [32:0]          span;
  logic [32:0]          limit;
  logic [32:0]          reach;
  logic [DistWidth-1:0] res_dist;
  logic [UsedWidth-1:0] used;
  logic                 bad;
  logic                 may_push;
  logic                 dict;

  assign sym = item_i.distance_symbol;

  // ring-relative codes
  assign ring_sel = ring_i[RING_PICK[sym[3:0]]];
  assign adj      = RING_ADJUST[sym[3:0]];
  assign rel_sum  = {2'b00, ring_sel} + {{23{adj[2]}}, adj};
  assign rel_bad  = rel_sum[25] || (rel_sum == 26'd0) || (rel_sum[24:0] > REL_LIMIT);

  assign direct_end = 11'(direct_codes_i) + 11'd16;
  assign in_direct  = {1'b0, sym} < direct_end;

  // extra-bit codes
  assign rel        = sym - 10'(direct_codes_i) - 10'd16;
  assign alpha_size = 10'd48 << postfix_bits_i;
  assign nshift     = {1'b0, postfix_bits_i} + 3'd1;
  assign rel_hi     = rel >> nshift;
  assign nbits      = 5'(rel_hi) + 5'd1;
  assign hcode_lsb  = rel[postfix_bits_i];
  assign lmask      = 3'((4'd1 << postfix_bits_i) - 4'd1);
  assign lcode      = rel[2:0] & lmask;
  assign emask      = ~(25'h1FF_FFFF << nbits);
  assign extra      = item_i.peek_bits & emask[23:0];
  assign offset     = ({25'd0, 1'b1, hcode_lsb} << nbits) - 27'd4;
  assign base       = offset + {3'b000, extra};
  assign ext_dist   = (30'(base) << postfix_bits_i) + 30'(lcode)
                    + 30'(direct_codes_i) + 30'd1;

  always_comb begin
    res_dist = '0;
    used     = '0;
    bad      = 1'b0;
    may_push = 1'b0;
    priority if (item_i.implicit_last) begin
      res_dist = 30'(ring_i[0]);
    end else if (sym < 10'd16) begin
      bad      = rel_bad;
      res_dist = 30'(rel_sum);
      may_push = (sym != 10'd0);
    end else if (in_direct) begin
      res_dist = 30'(sym - 10'd15);
      may_push = 1'b1;
    end else if (rel >= alpha_size) begin
      bad = 1'b1;
    end else begin
      res_dist = ext_dist;
      used     = nbits;
      may_push = 1'b1;
    end
  end

  // backward reach: min(2^window_bits - 16, position), floor at zero
  assign span  = 33'd1 << window_bits_i;
  assign limit = (span > WINDOW_SLACK) ? span - WINDOW_SLACK : 33'd0;
  assign reach = ({1'b0, item_i.output_position} < limit)
               ? {1'b0, item_i.output_position} : limit;
  assign dict  = {3'b000, res_dist} > reach;

  always_comb begin
    if (bad) begin
      result_o = '{resolved_distance: '0, bits_consumed: '0,
                   dictionary_ref: 1'b0, invalid_distance: 1'b1};
    end else begin
      result_o = '{resolved_distance: res_dist, bits_consumed: used,
                   dictionary_ref: dict, invalid_distance: 1'b0};
    end
  end

  assign upd_o.push      = !bad && may_push && !dict;
  assign upd_o.ring_dist = res_dist[23:0];

endmodule

// ===== rtl/bdd_ring.sv =====
// ----------------------------------------------------------------------------
// bdd_ring
// Ring of the last four distances, newest in entry 0.
// ----------------------------------------------------------------------------
module bdd_ring (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               commit_i,
  input  bdd_pkg::ring_upd_t upd_i,
  output bdd_pkg::ring_t     ring_o
);
  import bdd_pkg::*;

  ring_t ring_q;
  ring_t ring_d;

  always_comb begin
    ring_d = ring_q;
    if (commit_i && upd_i.push) begin
      ring_d = {ring_q[2:0], upd_i.ring_dist};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= RING_START;
    end else begin
      ring_q <= ring_d;
    end
  end

  assign ring_o = ring_q;

endmodule

// ===== rtl/brotli_distance_decoder_core.sv =====
// ----------------------------------------------------------------------------
// brotli_distance_decoder_core
// Path: input register stage, then result register. Throughput: one
// transaction per cycle while the master side accepts; the ring is read
// from the input register stage and updated as that stage hands its
// result on. Reset: asynchronous, clears both stage valids, loads ring
// 4,11,15,16 and registers postfix_bits 0, direct_codes 0, window_bits 16.
// ----------------------------------------------------------------------------
module brotli_distance_decoder_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [bdd_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [bdd_pkg::CfgDataWidth-1:0]  cfg_wdata_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // distance_symbol[9:0], peek_bits[33:10], output_position[65:34], zero pad
  input  logic [bdd_pkg::InDataWidth-1:0]   s_axis_tdata,
  // implicit_last[0]
  input  logic                              s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // resolved_distance[29:0], bits_consumed[34:30], zero pad
  output logic [bdd_pkg::OutDataWidth-1:0]  m_axis_tdata,
  // dictionary_ref[0], invalid_distance[1]
  output logic [1:0]                        m_axis_tuser
);
  import bdd_pkg::*;

  logic [PfxWidth-1:0] postfix_bits_q;
  logic [DirWidth-1:0] direct_codes_q;
  logic [WinWidth-1:0] window_bits_q;

  logic      in_valid_q;
  item_t     in_item_q;
  logic      out_valid_q;
  result_t   out_res_q;

  logic      advance;
  logic      take;
  ring_t     ring;
  result_t   res;
  ring_upd_t upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      postfix_bits_q <= '0;
      direct_codes_q <= '0;
      window_bits_q  <= WINDOW_BITS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POSTFIX_BITS: postfix_bits_q <= cfg_wdata_i[PfxWidth-1:0];
        CFG_DIRECT_CODES: direct_codes_q <= cfg_wdata_i[DirWidth-1:0];
        CFG_WINDOW_BITS:  window_bits_q  <= cfg_wdata_i[WinWidth-1:0];
        default: ;
      endcase
    end
  end

  // input stage moves on when the result register is free or being drained
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_item_q <= '{implicit_last:   s_axis_tuser,
                     distance_symbol: s_axis_tdata[9:0],
                     peek_bits:       s_axis_tdata[33:10],
                     output_position: s_axis_tdata[65:34]};
    end
    if (advance && in_valid_q) begin
      out_res_q <= res;
    end
  end

  bdd_resolve u_resolve (
    .item_i         (in_item_q),
    .ring_i         (ring),
    .postfix_bits_i (postfix_bits_q),
    .direct_codes_i (direct_codes_q),
    .window_bits_i  (window_bits_q),
    .result_o       (res),
    .upd_o          (upd)
  );

  bdd_ring u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (advance && in_valid_q),
    .upd_i    (upd),
    .ring_o   (ring)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_res_q.bits_consumed, out_res_q.resolved_distance};
  assign m_axis_tuser  = {out_res_q.invalid_distance, out_res_q.dictionary_ref};

endmodule

// ===== rtl/bdd_checker.sv =====
// ----------------------------------------------------------------------------
// bdd_checker
// Port-level checks of the distance decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "brotli_distance_decoder_core_macros.svh"

module bdd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [bdd_pkg::OutDataWidth-1:0]  m_axis_tdata,
  input logic [1:0]                        m_axis_tuser
);
  import bdd_pkg::*;

  // invalid results carry no distance, no bits and no dictionary flag
  `BDD_ASSERT_IMP(a_invalid_clean, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata == '0 && !m_axis_tuser[0], "invalid result with nonzero fields")

  // at most 24 extra bits can be taken from the peek
  `BDD_ASSERT_IMP(a_used_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[34:30] <= 5'd24, "bits_consumed above 24")

  // extra-bit codes always resolve to a positive distance
  `BDD_ASSERT_IMP(a_extra_nonzero, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[34:30] != 5'd0, m_axis_tdata[29:0] != 30'd0, "zero distance on an extra-bit code")

  // a stalled result holds
  `BDD_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed under stall")

endmodule

bind brotli_distance_decoder_core bdd_checker u_bdd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb_brotli_distance_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_brotli_distance_decoder_core
// Streams distance symbols through the decoder under several register
// settings and compares every result with a cycle-free model of the ring,
// the direct and extra-bit codes and the window check, with random backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_brotli_distance_decoder_core;
  import bdd_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned LongHold   = 240;
  localparam int unsigned PhaseItems = 96;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [CfgDataWidth-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataWidth-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  brotli_distance_decoder_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // model state: last four distances, newest first, and register copies
  logic [RingWidth-1:0] recent_dist [RingDepth] = '{24'd4, 24'd11, 24'd15, 24'd16};
  logic [PfxWidth-1:0] pfx_cfg = '0;
  logic [DirWidth-1:0] ndirect_cfg = '0;
  logic [WinWidth-1:0] wbits_cfg = WINDOW_BITS_RST;

  item_t   symbol_q [$];
  result_t dist_expect_q [$];
  item_t   tx_item;
  result_t got_res, want_res;

  int err_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int dict_seen = 0;
  int invalid_seen = 0;
  int settings_run = 1;
  int tx_gap = 0;
  int rx_gap = 0;
  int rx_hold = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int stall_cycles = 0;
  bit calm = 1'b0;

  function automatic result_t resolve_distance(item_t it);
    result_t     r;
    longint      v;
    longint unsigned res_dist, reach, extra, offset;
    int unsigned sym, nd, pfx, rel, nbits, hcode, lcode;
    bit          bad, may_push, dict;
    r = '0;
    res_dist = 0;
    nbits = 0;
    bad = 1'b0;
    may_push = 1'b0;
    sym = it.distance_symbol;
    nd = ndirect_cfg;
    pfx = pfx_cfg;
    if (it.implicit_last) begin
      res_dist = recent_dist[0];
    end else if (sym < 16) begin
      v = longint'(recent_dist[RING_PICK[sym]]) + longint'(RING_ADJUST[sym]);
      if (v <= 0 || v > (longint'(1) << 24)) bad = 1'b1;
      else res_dist = longint'(v);
      may_push = (sym != 0);
    end else if (sym < nd + 16) begin
      res_dist = sym - 15;
      may_push = 1'b1;
    end else begin
      rel = sym - nd - 16;
      if (rel >= (48 << pfx)) begin
        bad = 1'b1;
      end else begin
        nbits = 1 + (rel >> (pfx + 1));
        hcode = rel >> pfx;
        lcode = rel & ((1 << pfx) - 1);
        extra = longint'(it.peek_bits) & ((64'd1 << nbits) - 1);
        offset = ((64'd2 + (hcode & 1)) << nbits) - 4;
        res_dist = ((offset + extra) << pfx) + lcode + nd + 1;
        may_push = 1'b1;
      end
    end
    if (bad) begin
      r.invalid_distance = 1'b1;
      return r;
    end
    reach = 64'd1 << wbits_cfg;
    reach = (reach > 16) ? reach - 16 : 0;
    if (longint'(it.output_position) < reach) reach = it.output_position;
    dict = res_dist > reach;
    if (!dict && may_push) begin
      recent_dist[3] = recent_dist[2];
      recent_dist[2] = recent_dist[1];
      recent_dist[1] = recent_dist[0];
      recent_dist[0] = res_dist[RingWidth-1:0];
    end
    r.resolved_distance = res_dist[DistWidth-1:0];
    r.bits_consumed = nbits[UsedWidth-1:0];
    r.dictionary_ref = dict;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
    err_count++;
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        dist_expect_q.push_back(resolve_distance(tx_item));
        items_sent++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (!calm && tx_gap == 0 && $urandom_range(0, 11) == 0) tx_gap = $urandom_range(1, 9);
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (symbol_q.size() > 0) begin
          tx_item = symbol_q.pop_front();
          s_axis_tdata <= {6'b0, tx_item.output_position, tx_item.peek_bits,
                           tx_item.distance_symbol};
          s_axis_tuser <= tx_item.implicit_last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_res.resolved_distance = m_axis_tdata[29:0];
        got_res.bits_consumed = m_axis_tdata[34:30];
        got_res.dictionary_ref = m_axis_tuser[0];
        got_res.invalid_distance = m_axis_tuser[1];
        results_seen++;
        if (dist_expect_q.size() == 0) begin
          report_mismatch("unexpected transaction, distance", 0, got_res.resolved_distance);
        end else begin
          want_res = dist_expect_q.pop_front();
          dict_seen += want_res.dictionary_ref;
          invalid_seen += want_res.invalid_distance;
          if (got_res.resolved_distance != want_res.resolved_distance)
            report_mismatch("resolved_distance", want_res.resolved_distance,
                            got_res.resolved_distance);
          if (got_res.bits_consumed != want_res.bits_consumed)
            report_mismatch("bits_consumed", want_res.bits_consumed, got_res.bits_consumed);
          if (got_res.dictionary_ref != want_res.dictionary_ref)
            report_mismatch("dictionary_ref", want_res.dictionary_ref, got_res.dictionary_ref);
          if (got_res.invalid_distance != want_res.invalid_distance)
            report_mismatch("invalid_distance", want_res.invalid_distance,
                            got_res.invalid_distance);
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        rx_hold = LongHold;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        rx_gap = $urandom_range(1, 9) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with work outstanding but no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni && (symbol_q.size() > 0 || dist_expect_q.size() > 0 || s_axis_tvalid) &&
        !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready))
      stall_cycles++;
    else
      stall_cycles = 0;
    if (stall_cycles >= StallLimit) begin
      $display("timeout: no transaction for %0d cycles", StallLimit);
      $display("tb_brotli_distance_decoder_core: done, errors");
      $finish;
    end
  end

  function automatic item_t make_item();
    item_t       it;
    int unsigned nd, alpha_end, pick;
    nd = ndirect_cfg;
    alpha_end = 16 + nd + (48 << pfx_cfg);
    it.implicit_last = 1'b0;
    it.peek_bits = 24'($urandom_range(0, 24'hFF_FFFF));
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      it.implicit_last = 1'b1;
      it.distance_symbol = 10'($urandom_range(0, 1023));
    end else if (pick < 38) begin
      it.distance_symbol = 10'($urandom_range(0, 15));
    end else if (pick < 50 && nd > 0) begin
      it.distance_symbol = 10'($urandom_range(16, 15 + nd));
    end else if (pick < 85) begin
      // short extra-bit codes keep small distances in the ring
      if ($urandom_range(0, 2) == 0) it.distance_symbol = 10'(16 + nd + $urandom_range(0, 7));
      else it.distance_symbol = 10'($urandom_range(16 + nd, alpha_end - 1));
    end else if (pick < 92) begin
      it.distance_symbol = 10'($urandom_range(alpha_end, 1023));
    end else begin
      it.distance_symbol = 10'($urandom_range(0, 1023));
    end
    pick = $urandom_range(0, 9);
    if (pick < 6) it.output_position = $urandom;
    else if (pick < 8) it.output_position = $urandom_range(0, 4096);
    else if (pick == 8) it.output_position = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
    else it.output_position = $urandom_range(0, 1 << wbits_cfg);
    return it;
  endfunction

  task automatic add_item(logic impl, int unsigned sym, logic [23:0] peek, logic [31:0] pos);
    item_t it;
    it.implicit_last = impl;
    it.distance_symbol = 10'(sym);
    it.peek_bits = peek;
    it.output_position = pos;
    symbol_q.push_back(it);
  endtask

  task automatic wait_idle();
    while (symbol_q.size() > 0 || dist_expect_q.size() > 0 || s_axis_tvalid)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_settings(int unsigned pfx, int unsigned nd, int unsigned wb);
    write_reg(CFG_POSTFIX_BITS, CfgDataWidth'(pfx));
    write_reg(CFG_DIRECT_CODES, CfgDataWidth'(nd));
    write_reg(CFG_WINDOW_BITS, CfgDataWidth'(wb));
    pfx_cfg = PfxWidth'(pfx);
    ndirect_cfg = DirWidth'(nd);
    wbits_cfg = WinWidth'(wb);
    settings_run++;
  endtask

  int unsigned set_pfx [7] = '{3, 0, 1, 2, 0, 3, 0};
  int unsigned set_nd  [7] = '{120, 0, 37, 8, 120, 0, 0};
  int unsigned set_wb  [7] = '{24, 9, 12, 20, 16, 9, 16};

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: postfix 0, no direct codes, window 16
    add_item(1'b0, 16, 24'h0, 32'd1000);        // distance 1 enters the ring
    add_item(1'b0, 4, 24'h0, 32'd1000);         // last minus one gives zero
    add_item(1'b0, 6, 24'h0, 32'd1000);         // last minus two goes negative
    add_item(1'b0, 0, 24'h0, 32'd1000);         // reuse without ring update
    add_item(1'b1, 1023, 24'hFF_FFFF, 32'd0);   // implicit at position zero
    for (int s = 1; s < 16; s++)
      add_item(1'b0, s, 24'($urandom_range(0, 24'hFF_FFFF)), 32'hFFFF_FFFF);
    add_item(1'b0, 63, 24'hFF_FFFF, 32'hFFFF_FFFF);   // widest extra-bit code
    add_item(1'b0, 64, 24'h0, 32'hFFFF_FFFF);         // first symbol past the alphabet
    add_item(1'b0, 1023, 24'hFF_FFFF, 32'hFFFF_FFFF);
    add_item(1'b0, 16, 24'h1, 32'd0);
    add_item(1'b0, 40, 24'h00_0000, 32'h0000_8000);
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      if (p == 6) begin
        set_pfx[6] = $urandom_range(0, 3);
        set_nd[6] = $urandom_range(0, 120);
        set_wb[6] = $urandom_range(9, 24);
        calm = 1'b1;
      end
      apply_settings(set_pfx[p], set_nd[p], set_wb[p]);
      @(negedge clk_i);
      for (int i = 0; i < PhaseItems; i++) symbol_q.push_back(make_item());
      // back up the pipe with the sender still offering
      if (p == 0) hold_req++;
      wait_idle();
    end

    $display("%0d transactions sent, %0d results checked over %0d register settings",
             items_sent, results_seen, settings_run);
    $display("%0d dictionary references and %0d invalid distances seen",
             dict_seen, invalid_seen);
    if (err_count == 0) begin
      $display("tb_brotli_distance_decoder_core: done, clean");
    end else begin
      $display("tb_brotli_distance_decoder_core: done, errors");
    end
    $finish;
  end

endmodule
